>>> rtl/tlpq_pkg.sv
// Package: shared constants, codes and control/status types of the three-level priority queue.
package tlpq_pkg;

	localparam int LEVEL_CAPACITY = 16;
	localparam int NUM_LEVELS     = 3;
	localparam int STORE_DEPTH    = NUM_LEVELS * LEVEL_CAPACITY;
	localparam int IDX_W          = (LEVEL_CAPACITY > 1) ? $clog2(LEVEL_CAPACITY) : 1;
	localparam int CNT_W          = $clog2(LEVEL_CAPACITY + 1);
	localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int ID_W           = 16;
	localparam int AGE_W          = 8;
	localparam int LVL_W          = 2;
	localparam int STATUS_W       = 2;
	localparam int BATCH_W        = 2;
	localparam int WORD_W         = ID_W + AGE_W;

	localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SERVED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_SERVE = 1'b1;

	localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
	localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
	localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

	localparam logic [BATCH_W-1:0] BATCH_RESET = 2'd3;

	typedef struct packed {
		logic capture;
		logic add;
		logic pop;
		logic emit_empty;
		logic emit_served;
	} ctrl_cmd_t;

	typedef struct packed {
		logic any_entry;
		logic srv_last;
	} dp_sts_t;

endpackage

>>> rtl/three_level_priority_queue.sv
// Top level: three-level stable priority queue (controller, datapath, entry store).
//
//  channel  | signals                                         | transfer
//  ---------+-------------------------------------------------+-------------------------------
//  command  | start, busy, kind, entry_id/age/level           | start high while busy low
//  result   | strobe, status, out_id, out_age, out_level, last | every cycle strobe is high
//  config   | cfg_we, cfg_wdata (serve_batch)                 | every cycle cfg_we is high
//
// An add has a capture step and a store-write step; its result shows the cycle after the store write.
// A serve has a capture step, then a select step and a read step for each of n popped
// entries (n >= 0), plus a select step for the empty result when the queue runs out;
// each read uses the single store port with registered read.
// Reset clears pointers and counts and sets serve_batch to 3; the store is not cleared.
// Results cannot be stalled; each is shown for one cycle on strobe.
module three_level_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [tlpq_pkg::ID_W-1:0]         entry_id,
	input  logic [tlpq_pkg::AGE_W-1:0]        entry_age,
	input  logic [tlpq_pkg::LVL_W-1:0]        entry_level,
	input  logic                              cfg_we,
	input  logic [tlpq_pkg::BATCH_W-1:0]      cfg_wdata,
	output logic                              strobe,
	output logic [tlpq_pkg::STATUS_W-1:0]     status,
	output logic [tlpq_pkg::ID_W-1:0]         out_id,
	output logic [tlpq_pkg::AGE_W-1:0]        out_age,
	output logic [tlpq_pkg::LVL_W-1:0]        out_level,
	output logic                              last
);
	import tlpq_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	tlpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	tlpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.entry_id   (entry_id),
		.entry_age  (entry_age),
		.entry_level(entry_level),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.strobe     (strobe),
		.status     (status),
		.out_id     (out_id),
		.out_age    (out_age),
		.out_level  (out_level),
		.last       (last)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted but block not busy");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_ADDED || status == ST_FULL || status == ST_EMPTY) |-> last)
		else $error("add or empty result not marked last");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after last result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_SERVED |-> out_id == '0 && out_age == '0 && out_level == '0)
		else $error("non-served result carries payload");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> out_level != 2'd3)
		else $error("served level out of range");
`endif

endmodule

>>> rtl/tlpq_ram.sv
// Generic single-port RAM with registered read.
module tlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tlpq_ctrl.sv
// Controller: sequences add and serve transfers and drives datapath commands.
module tlpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                kind,
	input  tlpq_pkg::dp_sts_t   sts,
	output tlpq_pkg::ctrl_cmd_t cmd,
	output logic                busy
);
	import tlpq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SEL,
		S_RD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = (kind == KIND_SERVE) ? S_SEL : S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_IDLE;
			end
			S_SEL: begin
				if (sts.any_entry) begin
					cmd.pop = 1'b1;
					state_d = S_RD;
				end else begin
					cmd.emit_empty = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_RD: begin
				cmd.emit_served = 1'b1;
				state_d         = sts.srv_last ? S_IDLE : S_SEL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/tlpq_dp.sv
// Datapath: per-level ring pointers and counts, entry store, batch register, result registers.
module tlpq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlpq_pkg::ctrl_cmd_t               cmd,
	output tlpq_pkg::dp_sts_t                 sts,
	input  logic [tlpq_pkg::ID_W-1:0]         entry_id,
	input  logic [tlpq_pkg::AGE_W-1:0]        entry_age,
	input  logic [tlpq_pkg::LVL_W-1:0]        entry_level,
	input  logic                              cfg_we,
	input  logic [tlpq_pkg::BATCH_W-1:0]      cfg_wdata,
	output logic                              strobe,
	output logic [tlpq_pkg::STATUS_W-1:0]     status,
	output logic [tlpq_pkg::ID_W-1:0]         out_id,
	output logic [tlpq_pkg::AGE_W-1:0]        out_age,
	output logic [tlpq_pkg::LVL_W-1:0]        out_level,
	output logic                              last
);
	import tlpq_pkg::*;

	logic [IDX_W-1:0]    head_q [NUM_LEVELS];
	logic [IDX_W-1:0]    tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]    count_q [NUM_LEVELS];
	logic [BATCH_W-1:0]  batch_q;
	logic [BATCH_W-1:0]  pops_q;
	logic [ID_W-1:0]     id_q;
	logic [AGE_W-1:0]    age_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [LVL_W-1:0]    srv_lvl_q;
	logic                srv_last_q;

	logic                strobe_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [AGE_W-1:0]    out_age_q;
	logic [LVL_W-1:0]    out_level_q;
	logic                last_q;

	logic [LVL_W-1:0]    sel_lvl;
	logic                any_entry;
	logic                add_full;
	logic [BATCH_W-1:0]  batch_eff;
	logic [LVL_W-1:0]    acc_lvl;
	logic [ADDR_W-1:0]   ram_addr;
	logic                ram_we;
	logic [WORD_W-1:0]   ram_rdata;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(LEVEL_CAPACITY - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lv,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(lv) * ADDR_W'(LEVEL_CAPACITY) + ADDR_W'(idx);
	endfunction

	assign acc_lvl   = (entry_level > LVL_LOW) ? LVL_LOW : entry_level;
	assign any_entry = (count_q[0] != '0) || (count_q[1] != '0) || (count_q[2] != '0);
	assign sel_lvl   = (count_q[0] != '0) ? LVL_HIGH : ((count_q[1] != '0) ? LVL_MID : LVL_LOW);
	assign add_full  = (count_q[lvl_q] == CNT_W'(LEVEL_CAPACITY));
	assign batch_eff = (batch_q == '0) ? BATCH_W'(1) : batch_q;

	assign ram_we   = cmd.add && !add_full;
	assign ram_addr = cmd.add ? store_addr(lvl_q, tail_q[lvl_q]) :
		store_addr(sel_lvl, head_q[sel_lvl]);

	tlpq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (cmd.pop),
		.addr (ram_addr),
		.wdata({id_q, age_q}),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q   <= entry_id;
			age_q  <= entry_age;
			lvl_q  <= acc_lvl;
		end
		if (cmd.pop) begin
			srv_lvl_q  <= sel_lvl;
			srv_last_q <= ((pops_q + BATCH_W'(1)) == batch_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			batch_q     <= BATCH_RESET;
			pops_q      <= '0;
			strobe_q    <= 1'b0;
			status_q    <= ST_ADDED;
			out_id_q    <= '0;
			out_age_q   <= '0;
			out_level_q <= '0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				batch_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				pops_q <= '0;
			end
			if (cmd.add) begin
				if (!add_full) begin
					tail_q[lvl_q]  <= ring_next(tail_q[lvl_q]);
					count_q[lvl_q] <= count_q[lvl_q] + CNT_W'(1);
				end
				strobe_q    <= 1'b1;
				status_q    <= add_full ? ST_FULL : ST_ADDED;
				out_id_q    <= '0;
				out_age_q   <= '0;
				out_level_q <= '0;
				last_q      <= 1'b1;
			end
			if (cmd.pop) begin
				head_q[sel_lvl]  <= ring_next(head_q[sel_lvl]);
				count_q[sel_lvl] <= count_q[sel_lvl] - CNT_W'(1);
				pops_q           <= pops_q + BATCH_W'(1);
			end
			if (cmd.emit_empty) begin
				strobe_q    <= 1'b1;
				status_q    <= ST_EMPTY;
				out_id_q    <= '0;
				out_age_q   <= '0;
				out_level_q <= '0;
				last_q      <= 1'b1;
			end
			if (cmd.emit_served) begin
				strobe_q    <= 1'b1;
				status_q    <= ST_SERVED;
				out_id_q    <= ram_rdata[WORD_W-1:AGE_W];
				out_age_q   <= ram_rdata[AGE_W-1:0];
				out_level_q <= srv_lvl_q;
				last_q      <= srv_last_q;
			end
		end
	end

	assign sts.any_entry = any_entry;
	assign sts.srv_last  = srv_last_q;

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_age   = out_age_q;
	assign out_level = out_level_q;
	assign last      = last_q;

endmodule

>>> tb/tb_three_level_priority_queue.sv
// Testbench for the three-level priority queue: directed table then random traffic.
`timescale 1ns / 1ps

module tb_three_level_priority_queue;
	import tlpq_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [AGE_W-1:0]    age;
		logic [LVL_W-1:0]    level;
		logic                last;
	} queue_result_t;

	typedef struct packed {
		logic                kind;
		logic [ID_W-1:0]     id;
		logic [AGE_W-1:0]    age;
		logic [LVL_W-1:0]    level;
		logic                typed;
		logic [STATUS_W-1:0] typed_status;
	} cmd_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                kind;
	logic [ID_W-1:0]     entry_id;
	logic [AGE_W-1:0]    entry_age;
	logic [LVL_W-1:0]    entry_level;
	logic                cfg_we;
	logic [BATCH_W-1:0]  cfg_wdata;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_id;
	logic [AGE_W-1:0]    out_age;
	logic [LVL_W-1:0]    out_level;
	logic                last;

	queue_result_t awaited_results[$];
	cmd_row_t      script[$];
	queue_result_t pred_res[3];
	int            pred_n;
	int            errors = 0;

	logic [WORD_W-1:0]  lvl_words[NUM_LEVELS][LEVEL_CAPACITY];
	int                 lvl_head[NUM_LEVELS];
	int                 lvl_tail[NUM_LEVELS];
	int                 lvl_count[NUM_LEVELS];
	logic [BATCH_W-1:0] batch_reg;

	three_level_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.entry_id(entry_id),
		.entry_age(entry_age),
		.entry_level(entry_level),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.status(status),
		.out_id(out_id),
		.out_age(out_age),
		.out_level(out_level),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Queue behavior: fills pred_res / pred_n and advances the shadow state.
	task automatic predict_queue_op(input logic k, input logic [ID_W-1:0] id,
			input logic [AGE_W-1:0] age, input logic [LVL_W-1:0] lvl);
		int lv;
		int batch;
		int n;
		logic [WORD_W-1:0] w;
		pred_n = 0;
		if (k == KIND_ADD) begin
			lv = (lvl > LVL_LOW) ? int'(LVL_LOW) : int'(lvl);
			if (lvl_count[lv] >= LEVEL_CAPACITY) begin
				pred_res[0] = '{ST_FULL, '0, '0, '0, 1'b1};
			end else begin
				lvl_words[lv][lvl_tail[lv]] = {id, age};
				lvl_tail[lv] = (lvl_tail[lv] + 1) % LEVEL_CAPACITY;
				lvl_count[lv]++;
				pred_res[0] = '{ST_ADDED, '0, '0, '0, 1'b1};
			end
			pred_n = 1;
		end else begin
			batch = (batch_reg == 0) ? 1 : int'(batch_reg);
			for (n = 0; n < batch; n++) begin
				lv = 0;
				while (lv < NUM_LEVELS && lvl_count[lv] == 0)
					lv++;
				if (lv >= NUM_LEVELS) begin
					pred_res[pred_n] = '{ST_EMPTY, '0, '0, '0, 1'b1};
					pred_n++;
					break;
				end
				w = lvl_words[lv][lvl_head[lv]];
				lvl_head[lv] = (lvl_head[lv] + 1) % LEVEL_CAPACITY;
				lvl_count[lv]--;
				pred_res[pred_n] = '{ST_SERVED, w[WORD_W-1:AGE_W], w[AGE_W-1:0],
					LVL_W'(lv), (n + 1 == batch)};
				pred_n++;
			end
		end
	endtask

	task automatic script_row(input logic k, input logic [ID_W-1:0] id,
			input logic [AGE_W-1:0] age, input logic [LVL_W-1:0] lvl,
			input logic typed, input logic [STATUS_W-1:0] st);
		script.push_back('{k, id, age, lvl, typed, st});
	endtask

	task automatic send_command(input cmd_row_t r, input int idle_pct);
		int i;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		kind        <= r.kind;
		entry_id    <= r.id;
		entry_age   <= r.age;
		entry_level <= r.level;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_queue_op(r.kind, r.id, r.age, r.level);
		if (r.typed)
			awaited_results.push_back('{r.typed_status, '0, '0, '0, 1'b1});
		else
			for (i = 0; i < pred_n; i++)
				awaited_results.push_back(pred_res[i]);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_batch(input logic [BATCH_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		batch_reg  = v;
	endtask

	always @(posedge clk) begin : result_check
		queue_result_t got;
		queue_result_t want;
		if (arst_n && strobe) begin
			got = '{status, out_id, out_age, out_level, last};
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d id=%h age=%h level=%0d last=%b",
					$time, got.status, got.id, got.age, got.level, got.last);
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected status=%0d id=%h age=%h level=%0d last=%b",
						$time, want.status, want.id, want.age, want.level, want.last);
					$display("%0t:          actual   status=%0d id=%h age=%h level=%0d last=%b",
						$time, got.status, got.id, got.age, got.level, got.last);
				end
			end
		end
	end

	initial begin
		cmd_row_t r;
		int i;
		int p;
		int j;
		int batch_seq[4] = '{1, 0, 2, 3};
		int add_pct[4]   = '{45, 60, 80, 50};
		int idle_pct[4]  = '{0, 62, 0, 8};

		arst_n      = 1'b0;
		start       = 1'b0;
		kind        = KIND_ADD;
		entry_id    = '0;
		entry_age   = '0;
		entry_level = LVL_HIGH;
		cfg_we      = 1'b0;
		cfg_wdata   = BATCH_RESET;
		batch_reg   = BATCH_RESET;
		for (i = 0; i < NUM_LEVELS; i++) begin
			lvl_head[i]  = 0;
			lvl_tail[i]  = 0;
			lvl_count[i] = 0;
		end

		script_row(KIND_SERVE, '0, '0, LVL_HIGH, 1'b1, ST_EMPTY);
		script_row(KIND_ADD, 16'hFFFF, 8'hFF, LVL_HIGH, 1'b1, ST_ADDED);
		script_row(KIND_ADD, 16'h0000, 8'h00, LVL_MID, 1'b1, ST_ADDED);
		// level 3 lands in low
		script_row(KIND_ADD, 16'h5555, 8'hAA, 2'd3, 1'b1, ST_ADDED);
		script_row(KIND_SERVE, '0, '0, LVL_HIGH, 1'b0, ST_EMPTY);
		script_row(KIND_ADD, 16'hAAAA, 8'h55, LVL_LOW, 1'b1, ST_ADDED);
		script_row(KIND_SERVE, '0, '0, LVL_HIGH, 1'b0, ST_EMPTY);
		for (i = 0; i < LEVEL_CAPACITY; i++)
			script_row(KIND_ADD, ID_W'(16'h0100 + i * 16'h1111), AGE_W'(i * 17),
				LVL_LOW, 1'b1, ST_ADDED);
		script_row(KIND_ADD, 16'hBEEF, 8'h7F, LVL_LOW, 1'b1, ST_FULL);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_command(script[i], 0);

		for (p = 0; p < 4; p++) begin
			wait_drain();
			write_batch(BATCH_W'(batch_seq[p]));
			for (j = 0; j < 24; j++) begin
				if (j == 12)
					wait_drain();
				r.kind  = ($urandom_range(99) < add_pct[p]) ? KIND_ADD : KIND_SERVE;
				r.id    = ID_W'($urandom_range(65535));
				r.age   = AGE_W'($urandom_range(255));
				r.level = LVL_W'($urandom_range(3));
				r.typed = 1'b0;
				r.typed_status = ST_ADDED;
				send_command(r, idle_pct[p]);
			end
		end

		wait_drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> three_level_priority_queue.f
rtl/tlpq_pkg.sv
rtl/tlpq_ram.sv
rtl/tlpq_ctrl.sv
rtl/tlpq_dp.sv
rtl/three_level_priority_queue.sv
tb/tb_three_level_priority_queue.sv
